>>> hw/rtl/ffcr_pkg.sv
// Shared constants, types and command classification for the frame receiver.
package ffcr_pkg;

    localparam logic [7:0] FRAME_HEADER   = 8'h55;
    localparam logic [7:0] FRAME_TAIL     = 8'hdd;
    localparam logic [7:0] CMD_TASK_STATE = 8'haa;
    localparam logic [7:0] CMD_PEER_SPEED = 8'hbb;
    localparam logic [7:0] CMD_STOP       = 8'hcc;
    localparam logic [7:0] CMD_TASK_LOW   = 8'h01;
    localparam logic [7:0] CMD_TASK_HIGH  = 8'h06;

    typedef enum logic [2:0] {
        KIND_TASK_STATE = 3'd0,
        KIND_PEER_SPEED = 3'd1,
        KIND_STOP       = 3'd2,
        KIND_SET_TASK   = 3'd3,
        KIND_UNKNOWN    = 3'd4
    } frame_kind_t;

    typedef struct packed {
        frame_kind_t kind;
        logic [7:0]  command_byte;
        logic [7:0]  payload_byte;
    } frame_result_t;

    function automatic frame_kind_t classify(input logic [7:0] cmd);
        frame_kind_t kind;
        if (cmd == CMD_TASK_STATE)
        begin
            kind = KIND_TASK_STATE;
        end
        else if (cmd == CMD_PEER_SPEED)
        begin
            kind = KIND_PEER_SPEED;
        end
        else if (cmd == CMD_STOP)
        begin
            kind = KIND_STOP;
        end
        else if (cmd >= CMD_TASK_LOW && cmd <= CMD_TASK_HIGH)
        begin
            kind = KIND_SET_TASK;
        end
        else
        begin
            kind = KIND_UNKNOWN;
        end
        return kind;
    endfunction

endpackage

>>> hw/rtl/ffcr_in_stage.sv
// Input register: captures one received byte per transfer.
module ffcr_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_ready ? valid_next : valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

>>> hw/rtl/ffcr_parser.sv
// Frame position tracker, held bytes and result decode.
module ffcr_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    input  logic [7:0]             byte_data,
    input  logic                   advance,
    output logic                   res_valid,
    output ffcr_pkg::frame_result_t res
);

    typedef enum logic [3:0] {
        ST_HEADER  = 4'b0001,
        ST_COMMAND = 4'b0010,
        ST_PAYLOAD = 4'b0100,
        ST_TAIL    = 4'b1000
    } pos_t;

    pos_t       pos_reg;
    pos_t       pos_next;
    logic [7:0] command_reg;
    logic [7:0] payload_reg;

    always_comb
    begin
        case (pos_reg)
            ST_HEADER:  pos_next = (byte_data == ffcr_pkg::FRAME_HEADER) ? ST_COMMAND
                                                                         : ST_HEADER;
            ST_COMMAND: pos_next = ST_PAYLOAD;
            ST_PAYLOAD: pos_next = ST_TAIL;
            ST_TAIL:    pos_next = ST_HEADER;
            default:    pos_next = ST_HEADER;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= ST_HEADER;
            command_reg <= 8'h00;
            payload_reg <= 8'h00;
        end
        else if (advance)
        begin
            pos_reg <= pos_next;
            if (pos_reg == ST_COMMAND)
            begin
                command_reg <= byte_data;
            end
            if (pos_reg == ST_PAYLOAD)
            begin
                payload_reg <= byte_data;
            end
        end
    end

    // bad tail drops the frame; the tail byte is not retried as a header
    assign res_valid = byte_valid && (pos_reg == ST_TAIL)
                       && (byte_data == ffcr_pkg::FRAME_TAIL);

    assign res.kind         = ffcr_pkg::classify(command_reg);
    assign res.command_byte = command_reg;
    assign res.payload_byte = payload_reg;

endmodule

>>> hw/rtl/ffcr_out_reg.sv
// Result register on the master side.
module ffcr_out_reg (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  ffcr_pkg::frame_result_t res,
    output logic                    out_valid,
    input  logic                    out_ready,
    output ffcr_pkg::frame_result_t out_res
);

    logic                    valid_reg;
    logic                    valid_next;
    ffcr_pkg::frame_result_t res_reg;

    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

>>> hw/rtl/fixed_frame_command_receiver_top.sv
// Fixed-length command frame receiver: top level.
//
// Takes received serial bytes, one per transfer on the slave stream, and
// assembles 4-byte frames: header 0x55, command, payload, tail 0xdd. While
// hunting for a header every other byte is dropped. Inside a frame the
// command and payload are taken unchecked (a 0x55 there is just data). A
// frame whose fourth byte is not 0xdd is discarded whole and the hunt for
// a header starts with the next byte. Each good frame yields one transfer
// on the master stream: tuser carries the command class (0 task state,
// 1 peer speed, 2 stop, 3 set task and speed for 0x01..0x06,
// 4 unrecognised), tdata carries the command and payload bytes.
// Rate: one byte per cycle, save for the stall below. A byte is held in
// the input register; a result is loaded into the result register on
// the master side when its tail byte leaves the input register. The
// input side keeps taking bytes while a result waits, and only stalls when
// a second good frame completes while the result register is still full.
module fixed_frame_command_receiver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] command_byte, [15:8] payload_byte
    output logic [2:0]  m_axis_tuser    // [2:0] frame_kind
);

    logic                    byte_valid;
    logic [7:0]              byte_data;
    logic                    advance;
    logic                    res_valid;
    ffcr_pkg::frame_result_t res;
    ffcr_pkg::frame_result_t out_res;

    // The registered byte moves on unless it completes a frame while the
    // result register is full and not being drained.
    assign advance = byte_valid && (!res_valid || !m_axis_tvalid || m_axis_tready);

    ffcr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    ffcr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    ffcr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .res       (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {out_res.payload_byte, out_res.command_byte};
    assign m_axis_tuser = out_res.kind;

endmodule

>>> bench/tb_fixed_frame_command_receiver_top.sv
// Testbench for the command frame receiver: directed frames, random traffic, back-pressure.
module tb_fixed_frame_command_receiver_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Limit on consecutive cycles with no transfer on either side.
    localparam int IDLE_LIMIT  = 5000;
    // Length of the long receiver hold-off in the back-pressure test.
    localparam int HOLD_CYCLES = 150;
    // Cycles allowed after the last expected result before the verdict.
    localparam int DRAIN_CYCLES = 16;

    // Position of the next byte inside the 4-byte frame.
    typedef enum logic [1:0] {
        POS_HEADER  = 2'd0,
        POS_COMMAND = 2'd1,
        POS_PAYLOAD = 2'd2,
        POS_TAIL    = 2'd3
    } frame_pos_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [7:0] command_byte, [15:8] payload_byte
    logic [2:0]  m_axis_tuser;    // [2:0] frame_kind

    fixed_frame_command_receiver_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Frame tracker state, mirrors the receiver's own parse state.
    frame_pos_t              rx_pos;
    logic [7:0]              rx_command;
    logic [7:0]              rx_payload;
    // Frames that completed with a good tail, oldest first.
    ffcr_pkg::frame_result_t pending_frames[$];

    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    // Idle percentages for the two sides (per cycle).
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    // Set by the back-pressure test; the receiver process picks it up.
    logic        hold_request;
    int unsigned hold_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Classify a command byte the way the frame protocol defines it.
    function automatic ffcr_pkg::frame_kind_t command_class(input logic [7:0] cmd);
        ffcr_pkg::frame_kind_t k;
        if (cmd == ffcr_pkg::CMD_TASK_STATE)
            k = ffcr_pkg::KIND_TASK_STATE;
        else if (cmd == ffcr_pkg::CMD_PEER_SPEED)
            k = ffcr_pkg::KIND_PEER_SPEED;
        else if (cmd == ffcr_pkg::CMD_STOP)
            k = ffcr_pkg::KIND_STOP;
        else if (cmd >= ffcr_pkg::CMD_TASK_LOW && cmd <= ffcr_pkg::CMD_TASK_HIGH)
            k = ffcr_pkg::KIND_SET_TASK;
        else
            k = ffcr_pkg::KIND_UNKNOWN;
        return k;
    endfunction

    // Advance the frame tracker by one accepted byte; queue a result on a good tail.
    function automatic void track_rx_byte(input logic [7:0] b);
        ffcr_pkg::frame_result_t r;
        case (rx_pos)
            POS_HEADER:
            begin
                // anything but a header is dropped while hunting
                if (b == ffcr_pkg::FRAME_HEADER)
                    rx_pos = POS_COMMAND;
            end
            POS_COMMAND:
            begin
                rx_command = b;
                rx_pos     = POS_PAYLOAD;
            end
            POS_PAYLOAD:
            begin
                rx_payload = b;
                rx_pos     = POS_TAIL;
            end
            default:
            begin
                // bad tail: frame dropped, tail byte not re-examined as header
                rx_pos = POS_HEADER;
                if (b == ffcr_pkg::FRAME_TAIL)
                begin
                    r.kind         = command_class(rx_command);
                    r.command_byte = rx_command;
                    r.payload_byte = rx_payload;
                    pending_frames.push_back(r);
                end
            end
        endcase
    endfunction

    // Sample both streams at the rising edge: predict on input transfers,
    // compare on output transfers.
    always @(posedge clk)
    begin
        ffcr_pkg::frame_result_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                track_rx_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_frames.size() == 0)
                begin
                    $error("unexpected result: kind %0d command %02h payload %02h",
                           m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_frames.pop_front();
                    if (m_axis_tuser !== want.kind)
                    begin
                        $error("frame_kind mismatch: expected %0d, actual %0d",
                               want.kind, m_axis_tuser);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[7:0] !== want.command_byte)
                    begin
                        $error("command_byte mismatch: expected %02h, actual %02h",
                               want.command_byte, m_axis_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[15:8] !== want.payload_byte)
                    begin
                        $error("payload_byte mismatch: expected %02h, actual %02h",
                               want.payload_byte, m_axis_tdata[15:8]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog: any transfer on either side counts as progress.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver side: random stalls, plus one long hold-off on request.
    initial
    begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Offer one byte and wait for its transfer; returns at the following falling edge.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] pay,
                              input logic [7:0] tail);
        send_byte(ffcr_pkg::FRAME_HEADER);
        send_byte(cmd);
        send_byte(pay);
        send_byte(tail);
    endtask

    // Command mix: known commands, values from the set-task range, the
    // neighbors of its two ends, and fully random bytes.
    function automatic logic [7:0] pick_command();
        logic [7:0] c;
        case ($urandom_range(5))
            0:       c = ffcr_pkg::CMD_TASK_STATE;
            1:       c = ffcr_pkg::CMD_PEER_SPEED;
            2:       c = ffcr_pkg::CMD_STOP;
            3:       c = 8'($urandom_range(ffcr_pkg::CMD_TASK_HIGH, ffcr_pkg::CMD_TASK_LOW));
            4:       c = $urandom_range(1) ? (ffcr_pkg::CMD_TASK_LOW - 8'd1)
                                           : (ffcr_pkg::CMD_TASK_HIGH + 8'd1);
            default: c = 8'($urandom_range(255));
        endcase
        return c;
    endfunction

    task automatic test_directed_frames();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_byte(8'hff);                                   // dropped while hunting
        send_frame(ffcr_pkg::CMD_TASK_STATE, 8'h00, ffcr_pkg::FRAME_TAIL);
        send_frame(ffcr_pkg::CMD_PEER_SPEED, 8'hff, ffcr_pkg::FRAME_TAIL);
        // header value as payload
        send_frame(ffcr_pkg::CMD_STOP, ffcr_pkg::FRAME_HEADER, ffcr_pkg::FRAME_TAIL);
        // bad tail that looks like a header
        send_frame(ffcr_pkg::CMD_TASK_LOW, 8'h7f, ffcr_pkg::FRAME_HEADER);
        send_byte(ffcr_pkg::FRAME_TAIL);                    // dropped, not a header
        // tail value as payload
        send_frame(ffcr_pkg::CMD_TASK_HIGH, ffcr_pkg::FRAME_TAIL, ffcr_pkg::FRAME_TAIL);
        send_frame(8'h00, 8'h80, ffcr_pkg::FRAME_TAIL);     // unrecognised command
    endtask

    // Mostly good frames with random content; the rest bad tails and stray bytes.
    task automatic run_random_traffic(input int n_items);
        int         sent;
        int         roll;
        logic [7:0] tail;
        logic [7:0] stray;
        sent = 0;
        while (sent < n_items)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
            begin
                send_frame(pick_command(), 8'($urandom_range(255)), ffcr_pkg::FRAME_TAIL);
                sent += 4;
            end
            else if (roll < 85)
            begin
                tail = 8'($urandom_range(255));
                if (tail == ffcr_pkg::FRAME_TAIL)
                    tail = ~tail;
                send_frame(pick_command(), 8'($urandom_range(255)), tail);
                sent += 4;
            end
            else
            begin
                // stray byte; a stray header shifts the framing of what follows
                stray = ($urandom_range(3) == 0) ? ffcr_pkg::FRAME_HEADER
                                                 : 8'($urandom_range(255));
                send_byte(stray);
                sent++;
            end
        end
    endtask

    task automatic test_random_no_idle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_random_traffic(120);
    endtask

    task automatic test_random_sender_idle();
        src_idle_pct   = 83;
        sink_stall_pct = 0;
        run_random_traffic(120);
    endtask

    task automatic test_random_receiver_stall();
        src_idle_pct   = 0;
        sink_stall_pct = 83;
        run_random_traffic(120);
    endtask

    task automatic test_random_both_idle();
        src_idle_pct   = 8;
        sink_stall_pct = 8;
        run_random_traffic(120);
    endtask

    // Receiver holds off for a long stretch while good frames keep coming,
    // so the result register fills and the input side must stall.
    task automatic test_backpressure_fill();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_request   = 1'b1;
        repeat (12)
            send_frame(pick_command(), 8'($urandom_range(255)), ffcr_pkg::FRAME_TAIL);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'h00;
        hold_request   = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        rx_pos         = POS_HEADER;
        rx_command     = 8'h00;
        rx_payload     = 8'h00;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_frames();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_backpressure_fill();

        s_axis_tvalid <= 1'b0;
        sink_stall_pct = 0;
        // the watchdog bounds this wait
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
